// ----- design/gcct_pkg.sv -----
// ----------------------------------------------------------------------------
// gcct_pkg
// Shared constants, opcodes and controller/datapath command and status types
// for the graph coloring conflict tracker.
// ----------------------------------------------------------------------------
package gcct_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_COLORS   = 32;

	// field widths
	localparam int VTX_W   = 6;
	localparam int COL_W   = 6;
	localparam int VC_W    = 7;
	localparam int DELTA_W = 7;
	localparam int CONF_W  = 11;
	localparam int USED_W  = 6;
	localparam int MASK_W  = 32;

	// internal widths
	localparam int CIDX_W  = $clog2(MAX_COLORS);
	localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
	localparam int AVAIL_N = (MAX_COLORS < MASK_W) ? MAX_COLORS : MASK_W;
	localparam int TOP_CAP = AVAIL_N - 1;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_EDGE   = 2'd0;
	localparam opcode_t OP_ASSIGN = 2'd1;
	localparam opcode_t OP_EVAL   = 2'd2;

	typedef struct packed {
		logic capture;
		logic rd_v;
		logic rd_w;
		logic walk;
		logic wr_v;
		logic wr_w;
		logic apply;
		logic load;
	} gcct_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    bad;
		logic    edge_new;
		logic    walk_last;
		logic    out_busy;
	} gcct_stat_t;

endpackage

// ----- design/gcct_ifs.sv -----
// ----------------------------------------------------------------------------
// gcct_ifs
// Valid/ready channel interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
interface gcct_in_if;
	import gcct_pkg::*;

	logic                     valid;
	logic                     ready;
	opcode_t                  opcode;
	logic [VTX_W-1:0]         vertex;
	logic [VTX_W-1:0]         other_vertex;
	logic signed [COL_W-1:0]  color;

	modport source (output valid, opcode, vertex, other_vertex, color, input ready);
	modport sink   (input valid, opcode, vertex, other_vertex, color, output ready);
endinterface

interface gcct_out_if;
	import gcct_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DELTA_W-1:0] conflict_delta;
	logic                      color_is_valid;
	logic                      vertex_conflicts;
	logic [MASK_W-1:0]         available_mask;
	logic [CONF_W-1:0]         conflict_total;
	logic [USED_W-1:0]         colors_used;
	logic [VC_W-1:0]           uncolored_total;
	logic                      bad_vertex;

	modport source (output valid, conflict_delta, color_is_valid, vertex_conflicts,
		available_mask, conflict_total, colors_used, uncolored_total, bad_vertex,
		input ready);
	modport sink   (input valid, conflict_delta, color_is_valid, vertex_conflicts,
		available_mask, conflict_total, colors_used, uncolored_total, bad_vertex,
		output ready);
endinterface

// ----- design/gcct_ctrl.sv -----
// ----------------------------------------------------------------------------
// gcct_ctrl
// Sequencer: reads the two rows and colors, walks the neighbor colors,
// writes edges, applies the update and hands the result to the output.
// ----------------------------------------------------------------------------
module gcct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gcct_pkg::gcct_stat_t stat,
	output gcct_pkg::gcct_cmd_t  cmd
);
	import gcct_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RD_V   = 4'd1;
	localparam logic [3:0] ST_RD_W   = 4'd2;
	localparam logic [3:0] ST_DECIDE = 4'd3;
	localparam logic [3:0] ST_WALK   = 4'd4;
	localparam logic [3:0] ST_DRAIN  = 4'd5;
	localparam logic [3:0] ST_WR_V   = 4'd6;
	localparam logic [3:0] ST_WR_W   = 4'd7;
	localparam logic [3:0] ST_APPLY  = 4'd8;
	localparam logic [3:0] ST_LOAD   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RD_V;
				end
			end
			ST_RD_V: begin
				cmd.rd_v = 1'b1;
				state_d  = ST_RD_W;
			end
			ST_RD_W: begin
				cmd.rd_w = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.bad) begin
					state_d = ST_APPLY;
				end else begin
					case (stat.op)
						OP_EDGE:   state_d = stat.edge_new ? ST_WR_V : ST_APPLY;
						OP_ASSIGN: state_d = ST_WALK;
						OP_EVAL:   state_d = ST_WALK;
						default:   state_d = ST_APPLY;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_APPLY;
			end
			ST_WR_V: begin
				cmd.wr_v = 1'b1;
				state_d  = ST_WR_W;
			end
			ST_WR_W: begin
				cmd.wr_w = 1'b1;
				state_d  = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the output register is free
				if (!stat.out_busy) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/gcct_dp.sv -----
// ----------------------------------------------------------------------------
// gcct_dp
// Datapath: adjacency and color memories, colored flags, running counts,
// neighbor walk accumulators and the result register.
// ----------------------------------------------------------------------------
module gcct_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gcct_pkg::VC_W-1:0]            cfg_wdata,
	input  gcct_pkg::opcode_t                    in_opcode,
	input  logic [gcct_pkg::VTX_W-1:0]           in_vertex,
	input  logic [gcct_pkg::VTX_W-1:0]           in_other_vertex,
	input  logic signed [gcct_pkg::COL_W-1:0]    in_color,
	input  gcct_pkg::gcct_cmd_t                  cmd,
	output gcct_pkg::gcct_stat_t                 stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [gcct_pkg::DELTA_W-1:0]  out_conflict_delta,
	output logic                                 out_color_is_valid,
	output logic                                 out_vertex_conflicts,
	output logic [gcct_pkg::MASK_W-1:0]          out_available_mask,
	output logic [gcct_pkg::CONF_W-1:0]          out_conflict_total,
	output logic [gcct_pkg::USED_W-1:0]          out_colors_used,
	output logic [gcct_pkg::VC_W-1:0]            out_uncolored_total,
	output logic                                 out_bad_vertex
);
	import gcct_pkg::*;

	// item registers
	opcode_t                 op_q;
	logic [VTX_W-1:0]        v_q;
	logic [VTX_W-1:0]        w_q;
	logic signed [COL_W-1:0] c_q;
	logic                    bad_q;

	// configuration and running state
	logic [VC_W-1:0]         vc_q;
	logic [MAX_VERTICES-1:0] colored_q;
	logic [CONF_W-1:0]       conflict_q;
	logic [USED_W-1:0]       used_q;
	logic [CNT_W-1:0]        colored_cnt_q;

	// adjacency memory with per-row valid bits
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] adj_rd_raw_q;
	logic                    adj_rd_vld_q;
	logic [MAX_VERTICES-1:0] adj_rd;
	logic [VTX_W-1:0]        adj_ra;
	logic                    adj_re;
	logic [VTX_W-1:0]        adj_wa;
	logic                    adj_we;
	logic [MAX_VERTICES-1:0] adj_wd;
	logic [MAX_VERTICES-1:0] row_v_q;
	logic [MAX_VERTICES-1:0] bit_v;
	logic [MAX_VERTICES-1:0] bit_w;

	// color memory
	logic [CIDX_W-1:0]       col_mem [MAX_VERTICES];
	logic [CIDX_W-1:0]       col_rd_q;
	logic [VTX_W-1:0]        col_ra;
	logic                    col_re;
	logic                    col_we;
	logic [CIDX_W-1:0]       cv_q;

	// neighbor walk
	logic [VTX_W-1:0]        u_q;
	logic [VTX_W-1:0]        u_s1;
	logic                    walk_s1;
	logic                    nb;
	logic [CNT_W-1:0]        cnt_same_q;
	logic [CNT_W-1:0]        cnt_hit_q;
	logic [MAX_COLORS-1:0]   used_mask_q;

	// decode
	logic                    v_col;
	logic                    w_col;
	logic                    c_neg;
	logic                    c_fits;
	logic                    edge_new;
	logic                    assign_do;
	logic                    eval_do;
	logic [CONF_W-1:0]       conf_drop;
	logic [USED_W-1:0]       c_plus1;
	logic                    item_bad;

	// result
	logic signed [CNT_W:0]   delta_full;
	logic [CNT_W-1:0]        hit_eff;
	logic [CNT_W-1:0]        same_eff;
	logic [USED_W-1:0]       top;
	logic [MASK_W-1:0]       avail;
	logic [VC_W-1:0]         uncolored;
	logic                    out_valid_q;

	assign bit_v  = MAX_VERTICES'(1) << v_q;
	assign bit_w  = MAX_VERTICES'(1) << w_q;
	assign v_col  = colored_q[v_q];
	assign w_col  = colored_q[w_q];
	assign c_neg  = c_q[COL_W-1];
	assign c_fits = !c_neg && (int'($unsigned(c_q)) < MAX_COLORS);
	assign c_plus1 = USED_W'($unsigned(c_q)) + USED_W'(1);

	assign edge_new  = (op_q == OP_EDGE) && !bad_q && (v_q != w_q) && !row_v_q[w_q];
	assign assign_do = cmd.apply && (op_q == OP_ASSIGN) && !bad_q;
	assign eval_do   = (op_q == OP_EVAL) && !bad_q;
	assign conf_drop = v_col ? (conflict_q - CONF_W'(cnt_same_q)) : conflict_q;

	always_comb begin
		case (in_opcode)
			OP_EDGE:   item_bad = ({1'b0, in_vertex} >= vc_q) || ({1'b0, in_other_vertex} >= vc_q);
			OP_ASSIGN: item_bad = ({1'b0, in_vertex} >= vc_q);
			OP_EVAL:   item_bad = ({1'b0, in_vertex} >= vc_q);
			default:   item_bad = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_opcode;
			v_q   <= in_vertex;
			w_q   <= in_other_vertex;
			c_q   <= in_color;
			bad_q <= item_bad;
		end
	end

	// ---- adjacency memory ----
	assign adj_re = cmd.rd_v || cmd.rd_w;
	assign adj_ra = cmd.rd_w ? w_q : v_q;
	assign adj_we = cmd.wr_v || cmd.wr_w;
	assign adj_wa = cmd.wr_w ? w_q : v_q;
	assign adj_wd = cmd.wr_w ? (adj_rd | bit_v) : (row_v_q | bit_w);
	assign adj_rd = adj_rd_vld_q ? adj_rd_raw_q : '0;

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_raw_q <= adj_mem[adj_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			adj_rd_vld_q <= 1'b0;
		end else begin
			if (adj_we) begin
				row_vld_q[adj_wa] <= 1'b1;
			end
			if (adj_re) begin
				adj_rd_vld_q <= row_vld_q[adj_ra];
			end
		end
	end

	// row of v arrives while the read of w is issued
	always_ff @(posedge clk) begin
		if (cmd.rd_w) begin
			row_v_q <= adj_rd;
			cv_q    <= col_rd_q;
		end
	end

	// ---- color memory ----
	assign col_re = cmd.rd_v || cmd.rd_w || cmd.walk;
	assign col_ra = cmd.walk ? u_q : (cmd.rd_w ? w_q : v_q);
	assign col_we = assign_do && c_fits;

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[v_q] <= c_q[CIDX_W-1:0];
		end
		if (col_re) begin
			col_rd_q <= col_mem[col_ra];
		end
	end

	// ---- neighbor walk ----
	assign nb = walk_s1 && row_v_q[u_s1] && colored_q[u_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_s1 <= 1'b0;
			u_q     <= '0;
		end else begin
			walk_s1 <= cmd.walk;
			if (cmd.capture) begin
				u_q <= '0;
			end else if (cmd.walk) begin
				u_q <= u_q + VTX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		u_s1 <= u_q;
		if (cmd.capture) begin
			cnt_same_q  <= '0;
			cnt_hit_q   <= '0;
			used_mask_q <= '0;
		end else if (nb) begin
			if (col_rd_q == cv_q) begin
				cnt_same_q <= cnt_same_q + CNT_W'(1);
			end
			if (COL_W'(col_rd_q) == $unsigned(c_q)) begin
				cnt_hit_q <= cnt_hit_q + CNT_W'(1);
			end
			used_mask_q[col_rd_q] <= 1'b1;
		end
	end

	// ---- configuration and running state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q          <= VC_W'(MAX_VERTICES);
			colored_q     <= '0;
			conflict_q    <= '0;
			used_q        <= '0;
			colored_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				vc_q <= (cfg_wdata > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : cfg_wdata;
			end
			if (cmd.apply && edge_new && v_col && w_col && (cv_q == col_rd_q)) begin
				conflict_q <= conflict_q + CONF_W'(1);
			end
			if (assign_do) begin
				if (c_neg) begin
					if (v_col) begin
						conflict_q         <= conf_drop;
						colored_q[v_q]     <= 1'b0;
						colored_cnt_q      <= colored_cnt_q - CNT_W'(1);
					end
				end else if (c_fits) begin
					conflict_q <= conf_drop + CONF_W'(cnt_hit_q);
					if (!v_col) begin
						colored_q[v_q] <= 1'b1;
						colored_cnt_q  <= colored_cnt_q + CNT_W'(1);
					end
					if (c_plus1 > used_q) begin
						used_q <= c_plus1;
					end
				end
			end
		end
	end

	// ---- result ----
	assign hit_eff    = c_neg ? '0 : cnt_hit_q;
	assign same_eff   = v_col ? cnt_same_q : '0;
	assign delta_full = $signed({1'b0, hit_eff}) - $signed({1'b0, same_eff});
	assign top        = (used_q > USED_W'(TOP_CAP)) ? USED_W'(TOP_CAP) : used_q;
	assign uncolored  = (vc_q > VC_W'(colored_cnt_q)) ? (vc_q - VC_W'(colored_cnt_q)) : '0;

	always_comb begin
		avail = '0;
		for (int i = 0; i < AVAIL_N; i++) begin
			if ((USED_W'(i) <= top) && !used_mask_q[i]) begin
				avail[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_conflict_delta   <= eval_do ? DELTA_W'(delta_full) : '0;
			out_color_is_valid   <= eval_do && (c_neg || (cnt_hit_q == '0));
			out_vertex_conflicts <= eval_do && v_col && (cnt_same_q != '0);
			out_available_mask   <= eval_do ? avail : '0;
			out_conflict_total   <= conflict_q;
			out_colors_used      <= used_q;
			out_uncolored_total  <= uncolored;
			out_bad_vertex       <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	assign stat.op        = op_q;
	assign stat.bad       = bad_q;
	assign stat.edge_new  = edge_new;
	assign stat.walk_last = (u_q == VTX_W'(MAX_VERTICES - 1));
	assign stat.out_busy  = out_valid_q && !out_ready;

endmodule

// ----- design/graph_coloring_conflict_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// graph_coloring_conflict_tracker_unit
// Keeps an undirected graph of up to 64 vertices as an adjacency bit matrix
// (empty after reset), a color per vertex, the conflict-edge count, the
// number of colors used and the colored-vertex count. Each item adds an edge,
// assigns or clears a vertex color, or evaluates a vertex against a color,
// and yields one result carrying the status counts after the item. Items are
// handled one at a time. Assign and evaluate read the vertex rows and colors,
// decide, and walk all 64 neighbor slots in turn through the one read port of
// the color memory, then drain, apply and load the result. Add edge writes the
// two adjacency rows in place of the walk; other items go from decide straight
// to apply. A result waiting at the output holds the next item in its load
// step, and no new item is taken until that result moves into the output
// register.
// Write vertex_count only while idle.
// ----------------------------------------------------------------------------
module graph_coloring_conflict_tracker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gcct_pkg::VC_W-1:0]   cfg_wdata,
	gcct_in_if.sink                     item,
	gcct_out_if.source                  result
);
	import gcct_pkg::*;

	gcct_cmd_t  cmd;
	gcct_stat_t stat;

	gcct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	gcct_dp u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.in_opcode            (item.opcode),
		.in_vertex            (item.vertex),
		.in_other_vertex      (item.other_vertex),
		.in_color             (item.color),
		.cmd                  (cmd),
		.stat                 (stat),
		.out_valid            (result.valid),
		.out_ready            (result.ready),
		.out_conflict_delta   (result.conflict_delta),
		.out_color_is_valid   (result.color_is_valid),
		.out_vertex_conflicts (result.vertex_conflicts),
		.out_available_mask   (result.available_mask),
		.out_conflict_total   (result.conflict_total),
		.out_colors_used      (result.colors_used),
		.out_uncolored_total  (result.uncolored_total),
		.out_bad_vertex       (result.bad_vertex)
	);

endmodule
